FILE: hdl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Shared constants and types for the sorted set table and its key cells.
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int CAPACITY   = 1024;
    localparam int KEY_W      = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W  = 11;
    localparam int GROUP_SIZE = 32;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam logic [1:0] FUNC_MEMBER = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;

    // Broadcast command to every cell of the row
    typedef struct packed {
        logic sample;
        logic shift_up;
        logic shift_down;
    } cell_cmd_t;

endpackage

FILE: hdl/sst_cell.sv
// ----------------------------------------------------------------------------
// sst_cell
// One key slot: compares its key with the probe and shifts with its neighbours.
// ----------------------------------------------------------------------------
module sst_cell (
    input  logic                      clk,
    input  sst_pkg::cell_cmd_t        cmd,
    input  logic                      live,
    input  logic [sst_pkg::KEY_W-1:0] probe,
    input  logic [sst_pkg::KEY_W-1:0] key_lower,
    input  logic [sst_pkg::KEY_W-1:0] key_upper,
    input  logic                      lt_lower,
    output logic [sst_pkg::KEY_W-1:0] key_out,
    output logic                      lt_out,
    output logic                      eq_out
);

    logic [sst_pkg::KEY_W-1:0] key_reg;
    logic                      lt_reg;
    logic                      eq_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sample)
        begin
            lt_reg <= live && (key_reg < probe);
            eq_reg <= live && (key_reg == probe);
        end
        if (cmd.shift_up && !lt_reg)
        begin
            key_reg <= lt_lower ? probe : key_lower;
        end
        else if (cmd.shift_down && !lt_reg)
        begin
            key_reg <= key_upper;
        end
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule

FILE: hdl/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table
// Ordered set of distinct signed keys held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  channel | signals                                  | beat
//  --------+------------------------------------------+--------------------------
//  in      | in_valid, in_ready, func, key            | one operation
//  out     | out_valid, out_ready, success,           | one result per operation
//          | full_reject, entry_count                 |
//
//  Each item passes the steps accept, cell compare, grouped match reduce, execute.
//  The match reduce over all cells sets the length; a 32-wide OR per stage.
//  Reset clears the count and control; cell contents stay undefined.
//  Execute waits while a previous result is still held on the output.
//  in_ready is high only while no item is in flight.
// ----------------------------------------------------------------------------
module sorted_set_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [31:0] key,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               success,
    output logic               full_reject,
    output logic [10:0]        entry_count
);

    localparam int CAP   = sst_pkg::CAPACITY;
    localparam int CW    = sst_pkg::CNT_W;
    localparam int KW    = sst_pkg::KEY_W;
    localparam int OCW   = sst_pkg::OUT_CNT_W;
    localparam int GS    = sst_pkg::GROUP_SIZE;
    localparam int NG    = sst_pkg::NUM_GROUPS;
    localparam int PAD_W = NG * GS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_RED,
        ST_EXE
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          func_reg, func_next;
    logic [KW-1:0]       probe_reg, probe_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [NG-1:0]       group_reg, group_next;
    logic                out_valid_reg, out_valid_next;
    logic                success_reg, success_next;
    logic                full_reject_reg, full_reject_next;
    logic [OCW-1:0]      entry_count_reg, entry_count_next;

    sst_pkg::cell_cmd_t  cmd;
    logic [CAP-1:0]      live;
    logic [CAP-1:0]      lt_vec;
    logic [CAP-1:0]      eq_vec;
    logic [PAD_W-1:0]    eq_pad;
    logic [KW-1:0]       key_vec [CAP];

    logic                out_free;
    logic                present;
    logic                is_full;
    logic                do_insert;
    logic                do_delete;

    // ---------------- cell row ----------------
    for (genvar i = 0; i < CAP; i++)
    begin : g_cell
        logic [KW-1:0] lower_key;
        logic [KW-1:0] upper_key;
        logic          lower_lt;

        assign live[i] = (CW'(i) < count_reg);

        if (i == 0)
        begin : g_first
            assign lower_key = probe_reg;
            assign lower_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign lower_key = key_vec[i-1];
            assign lower_lt  = lt_vec[i-1];
        end

        if (i == CAP - 1)
        begin : g_last
            assign upper_key = key_vec[i];
        end
        else
        begin : g_body
            assign upper_key = key_vec[i+1];
        end

        sst_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .live      (live[i]),
            .probe     (probe_reg),
            .key_lower (lower_key),
            .key_upper (upper_key),
            .lt_lower  (lower_lt),
            .key_out   (key_vec[i]),
            .lt_out    (lt_vec[i]),
            .eq_out    (eq_vec[i])
        );
    end

    assign eq_pad = PAD_W'(eq_vec);

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = |eq_pad[g*GS +: GS];
        end
    end

    // ---------------- control ----------------
    assign out_free  = !out_valid_reg || out_ready;
    assign present   = |group_reg;
    assign is_full   = (count_reg == CW'(CAP));
    assign do_insert = (state_reg == ST_EXE) && out_free &&
                       (func_reg == sst_pkg::FUNC_INSERT) && !present && !is_full;
    assign do_delete = (state_reg == ST_EXE) && out_free &&
                       (func_reg == sst_pkg::FUNC_DELETE) && present;

    assign cmd.sample     = (state_reg == ST_CMP);
    assign cmd.shift_up   = do_insert;
    assign cmd.shift_down = do_delete;

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        probe_next       = probe_reg;
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        success_next     = success_reg;
        full_reject_next = full_reject_reg;
        entry_count_next = entry_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    probe_next = {~key[KW-1], key[KW-2:0]};
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_RED;
            end
            ST_RED:
            begin
                state_next = ST_EXE;
            end
            ST_EXE:
            begin
                if (out_free)
                begin
                    success_next     = 1'b0;
                    full_reject_next = 1'b0;
                    case (func_reg)
                        sst_pkg::FUNC_MEMBER:
                        begin
                            success_next = present;
                        end
                        sst_pkg::FUNC_INSERT:
                        begin
                            success_next     = !present && !is_full;
                            full_reject_next = !present && is_full;
                        end
                        sst_pkg::FUNC_DELETE:
                        begin
                            success_next = present;
                        end
                        default:
                        begin
                            success_next = 1'b0;
                        end
                    endcase
                    if (do_insert)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else if (do_delete)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    entry_count_next = OCW'(count_next);
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            func_reg        <= sst_pkg::FUNC_MEMBER;
            probe_reg       <= '0;
            count_reg       <= '0;
            group_reg       <= '0;
            out_valid_reg   <= 1'b0;
            success_reg     <= 1'b0;
            full_reject_reg <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            func_reg        <= func_next;
            probe_reg       <= probe_next;
            count_reg       <= count_next;
            group_reg       <= (state_reg == ST_RED) ? group_next : group_reg;
            out_valid_reg   <= out_valid_next;
            success_reg     <= success_next;
            full_reject_reg <= full_reject_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign success     = success_reg;
    assign full_reject = full_reject_reg;
    assign entry_count = entry_count_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAP))
        else $error("count beyond capacity");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow count");

    a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_delete |=> count_reg == $past(count_reg) - CW'(1))
        else $error("delete did not shrink count");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && full_reject_reg) |-> (!success_reg && is_full))
        else $error("reject without full store");

endmodule

FILE: sim/sorted_set_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_table_tb
// Self-checking bench for the sorted set table: member, insert and delete of
// signed keys on a valid/ready channel, checked beat by beat against a local
// ordered-set model that tracks the held keys and the entry count.
// ----------------------------------------------------------------------------
module sorted_set_table_tb;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         KEY_POOL_N  = 24;

    typedef struct packed {
        logic        success;
        logic        full_reject;
        logic [10:0] entry_count;
    } set_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic signed [31:0] key;
    logic               out_valid;
    logic               out_ready;
    logic               success;
    logic               full_reject;
    logic [10:0]        entry_count;

    logic signed [31:0] set_keys[$];
    set_result_t        pending_results[$];
    logic signed [31:0] key_pool[KEY_POOL_N];
    int                 error_count;
    bit                 no_gaps;

    sorted_set_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .success     (success),
        .full_reject (full_reject),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Applies one operation to the ordered set and returns its result
    function automatic set_result_t apply_set_op(input logic [1:0] f,
                                                 input logic signed [31:0] k);
        set_result_t r;
        int          pos;
        bit          hit;
        pos = 0;
        while (pos < set_keys.size() && set_keys[pos] < k)
            pos++;
        hit = (pos < set_keys.size()) && (set_keys[pos] == k);
        r = '0;
        case (f)
            sst_pkg::FUNC_MEMBER:
                r.success = hit;
            sst_pkg::FUNC_INSERT:
                if (!hit)
                begin
                    if (set_keys.size() >= sst_pkg::CAPACITY)
                        r.full_reject = 1'b1;
                    else
                    begin
                        set_keys.insert(pos, k);
                        r.success = 1'b1;
                    end
                end
            sst_pkg::FUNC_DELETE:
                if (hit)
                begin
                    set_keys.delete(pos);
                    r.success = 1'b1;
                end
            default:
                ;
        endcase
        r.entry_count = 11'(set_keys.size());
        return r;
    endfunction

    task automatic send_op(input logic [1:0] f, input logic signed [31:0] k);
        while (!no_gaps && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        key      <= k;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_set_op(f, k));
    endtask

    // Output side: random back-pressure and result checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_ready <= no_gaps || ($urandom_range(99) >= 13);
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat", $time);
                    error_count++;
                end
                else
                begin
                    set_result_t exp_r;
                    exp_r = pending_results.pop_front();
                    if (success !== exp_r.success)
                    begin
                        $display("%0t: success expected %0d actual %0d",
                                 $time, exp_r.success, success);
                        error_count++;
                    end
                    if (full_reject !== exp_r.full_reject)
                    begin
                        $display("%0t: full_reject expected %0d actual %0d",
                                 $time, exp_r.full_reject, full_reject);
                        error_count++;
                    end
                    if (entry_count !== exp_r.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, exp_r.entry_count, entry_count);
                        error_count++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_op(sst_pkg::FUNC_MEMBER, 32'sh8000_0000);
        send_op(sst_pkg::FUNC_DELETE, 32'sd7);
        send_op(sst_pkg::FUNC_INSERT, 32'sh8000_0000);
        send_op(sst_pkg::FUNC_INSERT, 32'sh7fff_ffff);
        send_op(sst_pkg::FUNC_INSERT, 32'sd0);
        send_op(sst_pkg::FUNC_INSERT, -32'sd1);
        send_op(sst_pkg::FUNC_INSERT, 32'sd1);
        send_op(sst_pkg::FUNC_INSERT, 32'sh7fff_ffff);
        send_op(sst_pkg::FUNC_MEMBER, 32'sh8000_0000);
        send_op(sst_pkg::FUNC_MEMBER, 32'sh7fff_ffff);
        send_op(sst_pkg::FUNC_MEMBER, 32'sd0);
        send_op(sst_pkg::FUNC_MEMBER, 32'sd5);
        send_op(FUNC_UNUSED, 32'sd0);
        send_op(sst_pkg::FUNC_DELETE, -32'sd1);
        send_op(sst_pkg::FUNC_DELETE, -32'sd1);
        send_op(sst_pkg::FUNC_MEMBER, -32'sd1);
        send_op(sst_pkg::FUNC_INSERT, 32'sh5555_5555);
        send_op(sst_pkg::FUNC_INSERT, 32'shaaaa_aaaa);
        send_op(sst_pkg::FUNC_MEMBER, 32'shaaaa_aaaa);
        send_op(sst_pkg::FUNC_DELETE, 32'sh8000_0000);
        send_op(sst_pkg::FUNC_DELETE, 32'sh7fff_ffff);
        send_op(sst_pkg::FUNC_DELETE, 32'sd0);
        send_op(sst_pkg::FUNC_DELETE, 32'sd1);
        send_op(FUNC_UNUSED, 32'shffff_ffff);
    endtask

    // Mixed operations on a small key pool so that hits are common
    task automatic test_random_ops(input int n_ops);
        int                 sel;
        logic [1:0]         f;
        logic signed [31:0] k;
        for (int i = 0; i < KEY_POOL_N; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int i = 0; i < n_ops; i++)
        begin
            no_gaps = (i >= n_ops / 2) && (i < n_ops / 2 + 150);
            sel = $urandom_range(99);
            if (sel < 5)
                f = FUNC_UNUSED;
            else if (sel < 45)
                f = sst_pkg::FUNC_INSERT;
            else if (sel < 70)
                f = sst_pkg::FUNC_DELETE;
            else
                f = sst_pkg::FUNC_MEMBER;
            if ($urandom_range(99) < 85)
                k = key_pool[$urandom_range(KEY_POOL_N - 1)];
            else
                k = $urandom;
            send_op(f, k);
        end
        no_gaps = 1'b0;
    endtask

    // Fill the store to capacity, then exercise the full-store cases
    task automatic test_full_store();
        logic signed [31:0] k;
        while (set_keys.size() < sst_pkg::CAPACITY)
        begin
            if ($urandom_range(99) < 8)
                send_op(sst_pkg::FUNC_MEMBER, $urandom);
            else
                send_op(sst_pkg::FUNC_INSERT, $urandom);
        end
        for (int i = 0; i < 70; i++)
        begin
            case ($urandom_range(5))
                0: send_op(sst_pkg::FUNC_INSERT, $urandom);
                1: send_op(sst_pkg::FUNC_INSERT,
                           set_keys[$urandom_range(set_keys.size() - 1)]);
                2: send_op(sst_pkg::FUNC_MEMBER,
                           set_keys[$urandom_range(set_keys.size() - 1)]);
                3: send_op(FUNC_UNUSED, $urandom);
                4:
                begin
                    k = set_keys[$urandom_range(set_keys.size() - 1)];
                    send_op(sst_pkg::FUNC_DELETE, k);
                    send_op(sst_pkg::FUNC_MEMBER, k);
                end
                default:
                    send_op(sst_pkg::FUNC_DELETE, $urandom);
            endcase
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = sst_pkg::FUNC_MEMBER;
        key         = '0;
        out_ready   = 1'b0;
        error_count = 0;
        no_gaps     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_random_ops(380);
        test_full_store();
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
